// File: rtl/core/pfc_pkg.sv
`default_nettype none
package pfc_pkg;

  // square geometry
  localparam int unsigned Side  = 5;
  localparam int unsigned Cells = Side * Side;

  typedef logic [4:0] letter_t;
  typedef logic [2:0] coord_t;
  typedef logic [4:0] cell_idx_t;

  // whole key square as seen by the search logic, cell k at [k]
  typedef logic [Cells-1:0][4:0] square_t;

  typedef enum logic [1:0] {
    ACT_LOAD = 2'd0,
    ACT_ENC  = 2'd1,
    ACT_DEC  = 2'd2
  } action_t;

  localparam letter_t LETTER_I = 5'd8;
  localparam letter_t LETTER_J = 5'd9;
  localparam coord_t  COORD_MAX = 3'(Side - 1);

  // result of a letter search
  typedef struct packed {
    logic   found;
    coord_t row;
    coord_t col;
  } loc_t;

  // row and column of each cell in row-major order
  localparam coord_t ROW_OF [Cells] = '{
    3'd0, 3'd0, 3'd0, 3'd0, 3'd0,
    3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
    3'd2, 3'd2, 3'd2, 3'd2, 3'd2,
    3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
    3'd4, 3'd4, 3'd4, 3'd4, 3'd4
  };
  localparam coord_t COL_OF [Cells] = '{
    3'd0, 3'd1, 3'd2, 3'd3, 3'd4,
    3'd0, 3'd1, 3'd2, 3'd3, 3'd4,
    3'd0, 3'd1, 3'd2, 3'd3, 3'd4,
    3'd0, 3'd1, 3'd2, 3'd3, 3'd4,
    3'd0, 3'd1, 3'd2, 3'd3, 3'd4
  };

  // one step right/down with wrap
  function automatic coord_t coord_inc(input coord_t c);
    coord_t r;
    r = (c == COORD_MAX) ? 3'd0 : coord_t'(c + 3'd1);
    return r;
  endfunction

  // one step left/up with wrap
  function automatic coord_t coord_dec(input coord_t c);
    coord_t r;
    r = (c == 3'd0) ? COORD_MAX : coord_t'(c - 3'd1);
    return r;
  endfunction

  // row * 5 + col
  function automatic cell_idx_t cell_addr(input coord_t row, input coord_t col);
    cell_idx_t a;
    a = cell_idx_t'({row, 2'b00}) + cell_idx_t'(row) + cell_idx_t'(col);
    return a;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/playfair_digraph_cipher_core.sv
`default_nettype none
// Playfair cipher engine on a 5x5 key square, one letter pair per cycle while out_stall is low.
// Input channel (in_valid/in_stall): each transaction is a load, an encrypt
// or a decrypt. A load writes one square cell (in_cell_index, letter in
// in_first_letter) and yields nothing; loads above cell 24 and action code 3
// are dropped. Encrypt/decrypt transactions take the pair in in_first_letter
// and in_second_letter and yield one result transaction on out_valid/out_stall
// with out_first, out_second and out_status (1 when a letter is not in the
// square, letters then read 0). The host loads all 25 cells before ciphering.
// From the input register a transaction goes through the 25-way compare into
// the position register, then the square read and the output register.
// Throughput is one transaction per cycle while out_stall is low, set by the four
// register stages, each of which advances independently; a load takes effect for
// every later transaction.
// Reset clears the pipeline valid bits only; the key square keeps its cells.
// When out_stall is high the output holds and the stages fill behind it;
// in_stall rises only once every stage is occupied.
module playfair_digraph_cipher_core (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_stall,
  input  wire [1:0]             in_action,
  input  wire [4:0]             in_cell_index,
  input  wire [4:0]             in_first_letter,
  input  wire [4:0]             in_second_letter,
  output logic                  out_valid,
  input  wire                   out_stall,
  output logic [4:0]            out_first,
  output logic [4:0]            out_second,
  output logic                  out_status
);

  // stage registers
  logic               v1_r, v2_r, v3_r, v4_r;
  logic [1:0]         act1_r;
  pfc_pkg::cell_idx_t idx1_r;
  pfc_pkg::letter_t   a1_r, b1_r;
  pfc_pkg::loc_t      loc_a2_r, loc_b2_r;
  logic               dec2_r;
  logic               ok3_r;
  pfc_pkg::letter_t   first4_r, second4_r;
  logic               status4_r;
  pfc_pkg::square_t   square_r;

  logic               rdy1, rdy2, rdy3, rdy4;
  logic               cipher1, load1, sq_wr;
  pfc_pkg::loc_t      loc_a, loc_b;
  pfc_pkg::coord_t    ra, ca, rb, cb;
  pfc_pkg::cell_idx_t addr_a, addr_b;
  logic               ok2;
  pfc_pkg::letter_t   rd_a, rd_b;

  // per-stage advance, bubbles collapse
  assign rdy4     = !v4_r || !out_stall;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_stall = !rdy1;

  // stage 1: input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (rdy1) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      act1_r <= in_action;
      idx1_r <= in_cell_index;
      a1_r   <= in_first_letter;
      b1_r   <= in_second_letter;
    end
  end

  // decode, square write happens as the load leaves stage 1
  assign cipher1 = (act1_r == pfc_pkg::ACT_ENC) || (act1_r == pfc_pkg::ACT_DEC);
  assign load1   = (act1_r == pfc_pkg::ACT_LOAD) && (idx1_r < 5'(pfc_pkg::Cells));
  assign sq_wr   = v1_r && load1 && rdy2;

  always_ff @(posedge clk) begin
    if (sq_wr) begin
      square_r[idx1_r] <= a1_r;
    end
  end

  // letter search against all cells
  pfc_locate u_loc_a (
    .square (square_r),
    .letter (a1_r),
    .loc    (loc_a)
  );

  pfc_locate u_loc_b (
    .square (square_r),
    .letter (b1_r),
    .loc    (loc_b)
  );

  // stage 2: positions of both letters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (rdy2) begin
      v2_r <= v1_r && cipher1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      loc_a2_r <= loc_a;
      loc_b2_r <= loc_b;
      dec2_r   <= (act1_r == pfc_pkg::ACT_DEC);
    end
  end

  // playfair rules: same row, same column, rectangle
  always_comb begin
    if (loc_a2_r.row == loc_b2_r.row) begin
      ra = loc_a2_r.row;
      rb = loc_b2_r.row;
      ca = dec2_r ? pfc_pkg::coord_dec(loc_a2_r.col) : pfc_pkg::coord_inc(loc_a2_r.col);
      cb = dec2_r ? pfc_pkg::coord_dec(loc_b2_r.col) : pfc_pkg::coord_inc(loc_b2_r.col);
    end else if (loc_a2_r.col == loc_b2_r.col) begin
      ra = dec2_r ? pfc_pkg::coord_dec(loc_a2_r.row) : pfc_pkg::coord_inc(loc_a2_r.row);
      rb = dec2_r ? pfc_pkg::coord_dec(loc_b2_r.row) : pfc_pkg::coord_inc(loc_b2_r.row);
      ca = loc_a2_r.col;
      cb = loc_b2_r.col;
    end else begin
      ra = loc_a2_r.row;
      rb = loc_b2_r.row;
      ca = loc_b2_r.col;
      cb = loc_a2_r.col;
    end
  end

  assign addr_a = pfc_pkg::cell_addr(ra, ca);
  assign addr_b = pfc_pkg::cell_addr(rb, cb);
  assign ok2    = loc_a2_r.found && loc_b2_r.found;

  // stage 3: square copy read for the output letters
  pfc_square_ram u_ram (
    .clk       (clk),
    .wr_en     (sq_wr),
    .wr_addr   (idx1_r),
    .wr_data   (a1_r),
    .rd_en     (rdy3),
    .rd_addr_a (addr_a),
    .rd_addr_b (addr_b),
    .rd_data_a (rd_a),
    .rd_data_b (rd_b)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (rdy3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      ok3_r <= ok2;
    end
  end

  // stage 4: output register, letters forced to zero on a miss
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (rdy4) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && v3_r) begin
      first4_r  <= ok3_r ? rd_a : '0;
      second4_r <= ok3_r ? rd_b : '0;
      status4_r <= !ok3_r;
    end
  end

  assign out_valid  = v4_r;
  assign out_first  = first4_r;
  assign out_second = second4_r;
  assign out_status = status4_r;

endmodule
`default_nettype wire

// File: rtl/core/pfc_locate.sv
`default_nettype none
module pfc_locate (
  input  wire pfc_pkg::square_t square,
  input  wire pfc_pkg::letter_t letter,
  output pfc_pkg::loc_t         loc
);

  pfc_pkg::letter_t want;

  // j is looked up as i
  assign want = (letter == pfc_pkg::LETTER_J) ? pfc_pkg::LETTER_I : letter;

  // 25-way compare, lowest matching cell wins
  always_comb begin
    loc = '0;
    for (int k = pfc_pkg::Cells - 1; k >= 0; k--) begin
      if (square[k] == want) begin
        loc.found = 1'b1;
        loc.row   = pfc_pkg::ROW_OF[k];
        loc.col   = pfc_pkg::COL_OF[k];
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/pfc_square_ram.sv
`default_nettype none
module pfc_square_ram (
  input  wire                     clk,
  input  wire                     wr_en,
  input  wire pfc_pkg::cell_idx_t wr_addr,
  input  wire pfc_pkg::letter_t   wr_data,
  input  wire                     rd_en,
  input  wire pfc_pkg::cell_idx_t rd_addr_a,
  input  wire pfc_pkg::cell_idx_t rd_addr_b,
  output pfc_pkg::letter_t        rd_data_a,
  output pfc_pkg::letter_t        rd_data_b
);

  pfc_pkg::letter_t mem [pfc_pkg::Cells];
  pfc_pkg::letter_t rd_a_r;
  pfc_pkg::letter_t rd_b_r;

  // single write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // two registered read ports, held while the next stage is stalled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_a_r <= mem[rd_addr_a];
      rd_b_r <= mem[rd_addr_b];
    end
  end

  assign rd_data_a = rd_a_r;
  assign rd_data_b = rd_b_r;

endmodule
`default_nettype wire

// File: test/tb_playfair_digraph_cipher_core.sv
module tb_playfair_digraph_cipher_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]  ACT_UNUSED   = 2'd3;
  localparam int unsigned IDLE_LIMIT   = 3000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned TARGET_ITEMS = 1350;
  localparam int unsigned PHASE_ITEMS  = 120;
  localparam int unsigned NUM_DIRECTED = 25;

  typedef struct packed {
    pfc_pkg::letter_t first;
    pfc_pkg::letter_t second;
    logic             status;
  } pair_out_t;

  typedef struct {
    logic [1:0]         act;
    pfc_pkg::cell_idx_t idx;
    pfc_pkg::letter_t   a;
    pfc_pkg::letter_t   b;
    logic               known;
    pair_out_t          want;
  } stim_row_t;

  // classic square: P L A Y F / I R E X M / B C D G H / K N O Q S / T U V W Z
  localparam pfc_pkg::letter_t KEY_SQUARE [pfc_pkg::Cells] = '{
    5'd15, 5'd11, 5'd0,  5'd24, 5'd5,
    5'd8,  5'd17, 5'd4,  5'd23, 5'd12,
    5'd1,  5'd2,  5'd3,  5'd6,  5'd7,
    5'd10, 5'd13, 5'd14, 5'd16, 5'd18,
    5'd19, 5'd20, 5'd21, 5'd22, 5'd25
  };

  // directed transactions on the classic square; known rows carry typed results
  stim_row_t directed_rows [NUM_DIRECTED] = '{
    '{pfc_pkg::ACT_ENC,  5'd0,  5'd24, 5'd5,  1'b1, '{5'd5,  5'd15, 1'b0}}, // Y F same row
    '{pfc_pkg::ACT_DEC,  5'd0,  5'd15, 5'd11, 1'b1, '{5'd5,  5'd15, 1'b0}}, // P L same row
    '{pfc_pkg::ACT_ENC,  5'd0,  5'd15, 5'd19, 1'b1, '{5'd8,  5'd15, 1'b0}}, // P T same column
    '{pfc_pkg::ACT_DEC,  5'd0,  5'd15, 5'd19, 1'b1, '{5'd19, 5'd10, 1'b0}}, // P T same column
    '{pfc_pkg::ACT_ENC,  5'd0,  5'd7,  5'd8,  1'b1, '{5'd1,  5'd12, 1'b0}}, // H I rectangle
    '{pfc_pkg::ACT_DEC,  5'd0,  5'd7,  5'd8,  1'b1, '{5'd1,  5'd12, 1'b0}}, // H I rectangle
    '{pfc_pkg::ACT_ENC,  5'd0,  5'd9,  5'd17, 1'b1, '{5'd17, 5'd4,  1'b0}}, // J looked up as I
    '{pfc_pkg::ACT_ENC,  5'd0,  5'd4,  5'd4,  1'b1, '{5'd23, 5'd23, 1'b0}}, // doubled E
    '{pfc_pkg::ACT_DEC,  5'd0,  5'd4,  5'd4,  1'b1, '{5'd17, 5'd17, 1'b0}}, // doubled E
    '{pfc_pkg::ACT_ENC,  5'd0,  5'd25, 5'd0,  1'b1, '{5'd21, 5'd5,  1'b0}}, // Z A extremes
    '{pfc_pkg::ACT_DEC,  5'd0,  5'd0,  5'd25, 1'b1, '{5'd5,  5'd21, 1'b0}}, // A Z extremes
    '{pfc_pkg::ACT_ENC,  5'd0,  5'd26, 5'd0,  1'b1, '{5'd0,  5'd0,  1'b1}}, // first not found
    '{pfc_pkg::ACT_DEC,  5'd0,  5'd0,  5'd31, 1'b1, '{5'd0,  5'd0,  1'b1}}, // second not found
    '{pfc_pkg::ACT_ENC,  5'd0,  5'd9,  5'd9,  1'b1, '{5'd17, 5'd17, 1'b0}}, // doubled J
    '{pfc_pkg::ACT_LOAD, 5'd31, 5'd31, 5'd31, 1'b0, '{5'd0,  5'd0,  1'b0}}, // load out of range
    '{ACT_UNUSED,        5'd31, 5'd31, 5'd31, 1'b0, '{5'd0,  5'd0,  1'b0}}, // unused action
    '{pfc_pkg::ACT_ENC,  5'd31, 5'd15, 5'd11, 1'b0, '{5'd0,  5'd0,  1'b0}}, // square untouched
    '{pfc_pkg::ACT_LOAD, 5'd24, 5'd15, 5'd0,  1'b0, '{5'd0,  5'd0,  1'b0}}, // P twice, Z gone
    '{pfc_pkg::ACT_ENC,  5'd0,  5'd25, 5'd0,  1'b1, '{5'd0,  5'd0,  1'b1}}, // Z no longer there
    '{pfc_pkg::ACT_DEC,  5'd0,  5'd15, 5'd22, 1'b0, '{5'd0,  5'd0,  1'b0}}, // first match wins
    '{pfc_pkg::ACT_LOAD, 5'd0,  5'd31, 5'd0,  1'b0, '{5'd0,  5'd0,  1'b0}}, // value above Z
    '{pfc_pkg::ACT_ENC,  5'd0,  5'd31, 5'd15, 1'b0, '{5'd0,  5'd0,  1'b0}},
    '{pfc_pkg::ACT_LOAD, 5'd0,  5'd15, 5'd0,  1'b0, '{5'd0,  5'd0,  1'b0}}, // restore square
    '{pfc_pkg::ACT_LOAD, 5'd24, 5'd25, 5'd0,  1'b0, '{5'd0,  5'd0,  1'b0}},
    '{pfc_pkg::ACT_ENC,  5'd0,  5'd22, 5'd10, 1'b0, '{5'd0,  5'd0,  1'b0}}
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] in_action = 2'd0;
  logic [4:0] in_cell_index = 5'd0;
  logic [4:0] in_first_letter = 5'd0;
  logic [4:0] in_second_letter = 5'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [4:0] out_first;
  logic [4:0] out_second;
  logic       out_status;

  // tracked copy of the key square and the pairs still to come out
  pfc_pkg::letter_t key_cells [pfc_pkg::Cells];
  pair_out_t        cipher_results_q [$];
  int unsigned      errors = 0;
  int unsigned      accepted_items = 0;
  int unsigned      idle_cycles = 0;
  bit               quiet = 1'b0;

  playfair_digraph_cipher_core i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_cell_index    (in_cell_index),
    .in_first_letter  (in_first_letter),
    .in_second_letter (in_second_letter),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_first        (out_first),
    .out_second       (out_second),
    .out_status       (out_status)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // idle length: mostly none, some short, a few long
  function automatic int unsigned pick_idle();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // 25-way search, lowest cell wins, J taken as I
  function automatic logic find_letter(input pfc_pkg::letter_t l, output int unsigned row,
                                       output int unsigned col);
    pfc_pkg::letter_t want;
    want = (l == pfc_pkg::LETTER_J) ? pfc_pkg::LETTER_I : l;
    row = 0;
    col = 0;
    for (int k = 0; k < pfc_pkg::Cells; k++) begin
      if (key_cells[k] == want) begin
        row = k / pfc_pkg::Side;
        col = k % pfc_pkg::Side;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic pfc_pkg::letter_t cell_at(input int unsigned row, input int unsigned col);
    return key_cells[(row % pfc_pkg::Side) * pfc_pkg::Side + (col % pfc_pkg::Side)];
  endfunction

  // applies one transaction to the tracked square; returns 1 when a pair comes out
  function automatic logic playfair_apply(input logic [1:0] act, input pfc_pkg::cell_idx_t idx,
                                          input pfc_pkg::letter_t a, input pfc_pkg::letter_t b,
                                          output pair_out_t res);
    int unsigned r1, c1, r2, c2, step;
    logic f1, f2;
    res = '0;
    if (act == pfc_pkg::ACT_LOAD) begin
      if (idx < pfc_pkg::Cells) key_cells[idx] = a;
      return 1'b0;
    end
    if (act != pfc_pkg::ACT_ENC && act != pfc_pkg::ACT_DEC) return 1'b0;
    f1 = find_letter(a, r1, c1);
    f2 = find_letter(b, r2, c2);
    if (!(f1 && f2)) begin
      res.status = 1'b1;
      return 1'b1;
    end
    // right/down on encrypt, left/up (plus four) on decrypt
    step = (act == pfc_pkg::ACT_ENC) ? 1 : pfc_pkg::Side - 1;
    if (r1 == r2) begin
      res.first  = cell_at(r1, c1 + step);
      res.second = cell_at(r2, c2 + step);
    end else if (c1 == c2) begin
      res.first  = cell_at(r1 + step, c1);
      res.second = cell_at(r2 + step, c2);
    end else begin
      res.first  = cell_at(r1, c2);
      res.second = cell_at(r2, c1);
    end
    return 1'b1;
  endfunction

  function automatic stim_row_t make_row(input logic [1:0] act, input pfc_pkg::cell_idx_t idx,
                                         input pfc_pkg::letter_t a, input pfc_pkg::letter_t b);
    stim_row_t row;
    row.act   = act;
    row.idx   = idx;
    row.a     = a;
    row.b     = b;
    row.known = 1'b0;
    row.want  = '0;
    return row;
  endfunction

  // random cell index within the given bounds, random letter over the full field range
  function automatic pfc_pkg::cell_idx_t rand_idx(input int unsigned lo, input int unsigned hi);
    return pfc_pkg::cell_idx_t'($urandom_range(lo, hi));
  endfunction

  function automatic pfc_pkg::letter_t rand_letter();
    return pfc_pkg::letter_t'($urandom_range(0, 31));
  endfunction

  // drive one transaction, wait for it to be taken, record what should come out
  task automatic send_item(input stim_row_t row);
    int unsigned gap;
    pair_out_t   res;
    logic        has_pair;
    gap = pick_idle();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_action        <= row.act;
    in_cell_index    <= row.idx;
    in_first_letter  <= row.a;
    in_second_letter <= row.b;
    do @(posedge clk); while (in_stall);
    has_pair = playfair_apply(row.act, row.idx, row.a, row.b, res);
    if (has_pair) begin
      cipher_results_q.insert(cipher_results_q.size(), row.known ? row.want : res);
      accepted_items++;
    end else if (row.act == pfc_pkg::ACT_LOAD && row.idx < pfc_pkg::Cells) begin
      accepted_items++;
    end
  endtask

  // letter taken from the current square, I sometimes given as J
  function automatic pfc_pkg::letter_t square_letter();
    pfc_pkg::letter_t l;
    l = key_cells[$urandom_range(0, pfc_pkg::Cells - 1)];
    if (l == pfc_pkg::LETTER_I && $urandom_range(0, 1) == 1) l = pfc_pkg::LETTER_J;
    return l;
  endfunction

  function automatic stim_row_t random_item();
    int unsigned      r;
    logic [1:0]       act;
    pfc_pkg::letter_t a;
    r   = $urandom_range(0, 99);
    act = ($urandom_range(0, 1) == 1) ? pfc_pkg::ACT_ENC : pfc_pkg::ACT_DEC;
    if (r < 80) begin
      a = square_letter();
      return make_row(act, rand_idx(0, 31), a,
                      ($urandom_range(0, 9) == 0) ? a : square_letter());
    end
    if (r < 88)
      return make_row(act, rand_idx(0, 31), rand_letter(), rand_letter());
    if (r < 93)
      return make_row(pfc_pkg::ACT_LOAD, rand_idx(0, pfc_pkg::Cells - 1), rand_letter(),
                      rand_letter());
    if (r < 97)
      return make_row(pfc_pkg::ACT_LOAD, rand_idx(pfc_pkg::Cells, 31), rand_letter(),
                      rand_letter());
    return make_row(ACT_UNUSED, rand_idx(0, 31), rand_letter(), rand_letter());
  endfunction

  // fresh shuffled square loaded in random cell order, then random items, mostly pairs
  task automatic run_phase();
    pfc_pkg::letter_t pool [pfc_pkg::Cells];
    int unsigned      order [pfc_pkg::Cells];
    int unsigned      n, j, t;
    pfc_pkg::letter_t tmp;
    n = 0;
    for (int l = 0; l < 26; l++) begin
      if (pfc_pkg::letter_t'(l) != pfc_pkg::LETTER_J) begin
        pool[n]  = pfc_pkg::letter_t'(l);
        order[n] = n;
        n++;
      end
    end
    for (int k = pfc_pkg::Cells - 1; k > 0; k--) begin
      j = $urandom_range(0, k);
      tmp = pool[k];
      pool[k] = pool[j];
      pool[j] = tmp;
      j = $urandom_range(0, k);
      t = order[k];
      order[k] = order[j];
      order[j] = t;
    end
    // now and then an odd square: duplicates or values above Z
    if ($urandom_range(0, 2) == 0) begin
      repeat ($urandom_range(1, 2)) pool[$urandom_range(0, pfc_pkg::Cells - 1)] = rand_letter();
    end
    for (int k = 0; k < pfc_pkg::Cells; k++)
      send_item(make_row(pfc_pkg::ACT_LOAD, pfc_pkg::cell_idx_t'(order[k]), pool[order[k]],
                         rand_letter()));
    repeat (PHASE_ITEMS) send_item(random_item());
  endtask

  // result side stall pattern
  initial begin
    int unsigned n;
    forever begin
      n = pick_idle();
      if (n != 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // compare each result transaction with the oldest expected pair
  always @(posedge clk) begin
    pair_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (cipher_results_q.size() == 0) begin
        $display("%0t: unexpected result, actual %0d %0d %0d", $time, out_first,
                 out_second, out_status);
        errors++;
      end else begin
        want = cipher_results_q.pop_front();
        check_field("out_first", 32'(want.first), 32'(out_first));
        check_field("out_second", 32'(want.second), 32'(out_second));
        check_field("out_status", 32'(want.status), 32'(out_status));
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("playfair_digraph_cipher_core verification failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    // full square before any pair, so no unwritten cell is ever searched
    for (int k = 0; k < pfc_pkg::Cells; k++)
      send_item(make_row(pfc_pkg::ACT_LOAD, pfc_pkg::cell_idx_t'(k), KEY_SQUARE[k],
                         rand_letter()));
    for (int k = 0; k < NUM_DIRECTED; k++) send_item(directed_rows[k]);
    while (accepted_items < TARGET_ITEMS) begin
      quiet = ($urandom_range(0, 3) == 0);
      run_phase();
      // hold off until the pipeline has drained
      in_valid <= 1'b0;
      while (cipher_results_q.size() != 0) @(posedge clk);
    end
    quiet = 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && cipher_results_q.size() == 0) begin
      $display("playfair_digraph_cipher_core verification clean");
    end else begin
      $display("playfair_digraph_cipher_core verification failed");
    end
    $finish;
  end

endmodule
